@@ src/frc_pkg.sv @@
// frc_pkg: widths, register indexes and the job record shared by the
// rate converter modules; no dependencies
`default_nettype none

package frc_pkg;

    localparam int SAMPLE_BITS = 8;
    localparam int MAX_RUN     = 64;
    localparam int RATE_BITS   = 16;

    localparam int PHASE_W     = RATE_BITS + 2;
    localparam int RUN_W       = $clog2(MAX_RUN + 1);
    localparam int PROD_W      = SAMPLE_BITS + RATE_BITS;
    localparam int BIT_W       = $clog2(SAMPLE_BITS);
    localparam int SILENCE_W   = 8;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = RATE_BITS;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_DEST_STEP     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_STEP   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SILENCE_LEVEL = 2'd2;

    localparam logic [RATE_BITS-1:0]   DEST_STEP_RESET   = RATE_BITS'(1);
    localparam logic [RATE_BITS-1:0]   SOURCE_STEP_RESET = RATE_BITS'(1);
    localparam logic [SILENCE_W-1:0]   SILENCE_RESET     = 8'd128;

    localparam logic signed [PHASE_W-1:0] PHASE_MIN = {1'b1, {(PHASE_W-1){1'b0}}};

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] cur_sample;
        logic [SAMPLE_BITS-1:0] nxt_sample;
        logic [RATE_BITS-1:0]   lo_step;
        logic [RATE_BITS-1:0]   hi_step;
        logic [RUN_W-1:0]       run_len;
        logic                   capped;
    } job_t;

endpackage

`default_nettype wire

@@ src/frc_front.sv @@
// frc_front: configuration registers, sample history and phase accumulator;
// counts the outputs owed per input and hands a job to the queue; uses frc_pkg
`default_nettype none

module frc_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [frc_pkg::SAMPLE_BITS-1:0] in_sample,
    input  logic                            cfg_wr_en,
    input  logic [frc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [frc_pkg::CFG_DATA_W-1:0]  cfg_data,
    output frc_pkg::job_t                   job,
    output logic                            job_push,
    input  logic                            job_full
);
    import frc_pkg::*;

    typedef enum logic [1:0] {F_IDLE, F_RUN, F_FINISH} front_state_t;

    front_state_t              state_reg, state_next;
    logic [RATE_BITS-1:0]      dest_step_reg, dest_step_next;
    logic [RATE_BITS-1:0]      source_step_reg, source_step_next;
    logic [SAMPLE_BITS-1:0]    cur_reg, cur_next;
    logic [SAMPLE_BITS-1:0]    nxt_reg, nxt_next;
    logic [SAMPLE_BITS-1:0]    sample_reg, sample_next;
    logic signed [PHASE_W-1:0] phase_reg, phase_next;
    logic [RUN_W-1:0]          cnt_reg, cnt_next;
    logic                      capped_reg, capped_next;

    logic signed [PHASE_W-1:0] ss_ext;
    logic signed [PHASE_W:0]   phase_diff;
    logic signed [PHASE_W-1:0] phase_sat;
    logic                      dest_lower;

    assign ss_ext     = $signed({2'b00, source_step_reg});
    assign phase_diff = $signed({phase_reg[PHASE_W-1], phase_reg})
                        - $signed({3'b000, dest_step_reg});
    assign phase_sat  = (phase_diff[PHASE_W] != phase_diff[PHASE_W-1])
                        ? PHASE_MIN : phase_diff[PHASE_W-1:0];
    assign dest_lower = dest_step_reg < source_step_reg;

    assign in_ready = (state_reg == F_IDLE);

    always_comb
    begin
        job.cur_sample = cur_reg;
        job.nxt_sample = nxt_reg;
        job.lo_step    = dest_lower ? dest_step_reg : source_step_reg;
        job.hi_step    = dest_lower ? source_step_reg : dest_step_reg;
        job.run_len    = cnt_reg;
        job.capped     = capped_reg;
    end

    always_comb
    begin
        state_next       = state_reg;
        dest_step_next   = dest_step_reg;
        source_step_next = source_step_reg;
        cur_next         = cur_reg;
        nxt_next         = nxt_reg;
        sample_next      = sample_reg;
        phase_next       = phase_reg;
        cnt_next         = cnt_reg;
        capped_next      = capped_reg;
        job_push         = 1'b0;

        case (state_reg)
            F_IDLE:
            begin
                if (in_valid)
                begin
                    sample_next = in_sample;
                    cnt_next    = '0;
                    capped_next = 1'b0;
                    state_next  = F_RUN;
                end
            end
            F_RUN:
            begin
                if (phase_reg < ss_ext)
                begin
                    if (cnt_reg == RUN_W'(MAX_RUN))
                    begin
                        capped_next = 1'b1;
                        state_next  = F_FINISH;
                    end
                    else
                    begin
                        phase_next = phase_reg + ss_ext;
                        cnt_next   = cnt_reg + 1'b1;
                    end
                end
                else
                begin
                    state_next = F_FINISH;
                end
            end
            F_FINISH:
            begin
                if (cnt_reg == '0 || !job_full)
                begin
                    job_push   = (cnt_reg != '0);
                    cur_next   = nxt_reg;
                    nxt_next   = sample_reg;
                    phase_next = phase_sat;
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase

        if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_DEST_STEP:
                begin
                    dest_step_next = cfg_data[RATE_BITS-1:0];
                    phase_next     = $signed({2'b00, cfg_data[RATE_BITS-1:0]});
                end
                REG_SOURCE_STEP:
                begin
                    source_step_next = cfg_data[RATE_BITS-1:0];
                end
                REG_SILENCE_LEVEL:
                begin
                    cur_next = SAMPLE_BITS'(cfg_data[SILENCE_W-1:0]);
                    nxt_next = SAMPLE_BITS'(cfg_data[SILENCE_W-1:0]);
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= F_IDLE;
            dest_step_reg   <= DEST_STEP_RESET;
            source_step_reg <= SOURCE_STEP_RESET;
            cur_reg         <= SAMPLE_BITS'(SILENCE_RESET);
            nxt_reg         <= SAMPLE_BITS'(SILENCE_RESET);
            phase_reg       <= $signed({2'b00, DEST_STEP_RESET});
            cnt_reg         <= '0;
            capped_reg      <= 1'b0;
            sample_reg      <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            dest_step_reg   <= dest_step_next;
            source_step_reg <= source_step_next;
            cur_reg         <= cur_next;
            nxt_reg         <= nxt_next;
            phase_reg       <= phase_next;
            cnt_reg         <= cnt_next;
            capped_reg      <= capped_next;
            sample_reg      <= sample_next;
        end
    end

`ifndef SYNTH
    assert property (@(posedge clk) disable iff (!rst_n)
        capped_reg |-> cnt_reg == RUN_W'(MAX_RUN))
        else $error("run flagged as capped below the run limit");
`endif

endmodule

`default_nettype wire

@@ src/frc_queue.sv @@
// frc_queue: short job queue between the front and back of the converter;
// uses frc_pkg for the job record and depth
`default_nettype none

module frc_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  frc_pkg::job_t push_data,
    output logic          full,
    input  logic          pop,
    output frc_pkg::job_t pop_data,
    output logic          empty
);
    import frc_pkg::*;

    localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

    job_t               entries_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [COUNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == COUNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTH
    assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
        else $error("job pushed into a full queue");
    assert property (@(posedge clk) disable iff (!rst_n) !(pop && empty))
        else $error("job popped from an empty queue");
`endif

endmodule

`default_nettype wire

@@ src/frc_back.sv @@
// frc_back: takes jobs from the queue, forms the interpolated sample with a
// multiply and a bit-serial divide, and emits the run; uses frc_pkg
`default_nettype none

module frc_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  frc_pkg::job_t                   job,
    input  logic                            job_empty,
    output logic                            job_pop,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [frc_pkg::SAMPLE_BITS-1:0] out_sample,
    output logic                            run_last,
    output logic                            run_capped
);
    import frc_pkg::*;

    typedef enum logic [1:0] {B_IDLE, B_MUL, B_DIV, B_EMIT} back_state_t;

    back_state_t            state_reg, state_next;
    logic [SAMPLE_BITS-1:0] cur_reg, cur_next;
    logic [SAMPLE_BITS-1:0] mag_reg, mag_next;
    logic                   neg_reg, neg_next;
    logic [RATE_BITS-1:0]   lo_reg, lo_next;
    logic [RATE_BITS-1:0]   hi_reg, hi_next;
    logic [RUN_W-1:0]       remain_reg, remain_next;
    logic                   capped_reg, capped_next;
    logic [PROD_W-1:0]      prod_reg, prod_next;
    logic [PROD_W-1:0]      div_reg, div_next;
    logic [SAMPLE_BITS-1:0] quo_reg, quo_next;
    logic [BIT_W-1:0]       bit_reg, bit_next;
    logic                   out_valid_reg, out_valid_next;
    logic [SAMPLE_BITS-1:0] out_sample_reg, out_sample_next;
    logic                   run_last_reg, run_last_next;
    logic                   run_capped_reg, run_capped_next;

    logic                   ge;
    logic [SAMPLE_BITS-1:0] interp;
    logic                   last_one;

    assign ge       = (prod_reg >= div_reg);
    assign interp   = (hi_reg == '0) ? cur_reg
                      : (neg_reg ? cur_reg - quo_reg : cur_reg + quo_reg);
    assign last_one = (remain_reg == RUN_W'(1));

    assign out_valid  = out_valid_reg;
    assign out_sample = out_sample_reg;
    assign run_last   = run_last_reg;
    assign run_capped = run_capped_reg;

    always_comb
    begin
        state_next      = state_reg;
        cur_next        = cur_reg;
        mag_next        = mag_reg;
        neg_next        = neg_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        remain_next     = remain_reg;
        capped_next     = capped_reg;
        prod_next       = prod_reg;
        div_next        = div_reg;
        quo_next        = quo_reg;
        bit_next        = bit_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_sample_next = out_sample_reg;
        run_last_next   = run_last_reg;
        run_capped_next = run_capped_reg;
        job_pop         = 1'b0;

        case (state_reg)
            B_IDLE:
            begin
                if (!job_empty)
                begin
                    job_pop     = 1'b1;
                    cur_next    = job.cur_sample;
                    neg_next    = job.nxt_sample < job.cur_sample;
                    mag_next    = (job.nxt_sample < job.cur_sample)
                                  ? job.cur_sample - job.nxt_sample
                                  : job.nxt_sample - job.cur_sample;
                    lo_next     = job.lo_step;
                    hi_next     = job.hi_step;
                    remain_next = job.run_len;
                    capped_next = job.capped;
                    state_next  = B_MUL;
                end
            end
            B_MUL:
            begin
                prod_next  = PROD_W'(mag_reg) * PROD_W'(lo_reg);
                div_next   = PROD_W'(hi_reg) << (SAMPLE_BITS - 1);
                quo_next   = '0;
                bit_next   = BIT_W'(SAMPLE_BITS - 1);
                state_next = B_DIV;
            end
            B_DIV:
            begin
                if (ge)
                begin
                    prod_next = prod_reg - div_reg;
                end
                quo_next = {quo_reg[SAMPLE_BITS-2:0], ge};
                div_next = div_reg >> 1;
                if (bit_reg == '0)
                begin
                    state_next = B_EMIT;
                end
                else
                begin
                    bit_next = bit_reg - 1'b1;
                end
            end
            B_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_sample_next = interp;
                    run_last_next   = last_one;
                    run_capped_next = last_one && capped_reg;
                    remain_next     = remain_reg - 1'b1;
                    if (last_one)
                    begin
                        state_next = B_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= B_IDLE;
            out_valid_reg  <= 1'b0;
            remain_reg     <= '0;
            bit_reg        <= '0;
            cur_reg        <= '0;
            mag_reg        <= '0;
            neg_reg        <= 1'b0;
            lo_reg         <= '0;
            hi_reg         <= '0;
            capped_reg     <= 1'b0;
            prod_reg       <= '0;
            div_reg        <= '0;
            quo_reg        <= '0;
            out_sample_reg <= '0;
            run_last_reg   <= 1'b0;
            run_capped_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            remain_reg     <= remain_next;
            bit_reg        <= bit_next;
            cur_reg        <= cur_next;
            mag_reg        <= mag_next;
            neg_reg        <= neg_next;
            lo_reg         <= lo_next;
            hi_reg         <= hi_next;
            capped_reg     <= capped_next;
            prod_reg       <= prod_next;
            div_reg        <= div_next;
            quo_reg        <= quo_next;
            out_sample_reg <= out_sample_next;
            run_last_reg   <= run_last_next;
            run_capped_reg <= run_capped_next;
        end
    end

`ifndef SYNTH
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && run_capped_reg) |-> run_last_reg)
        else $error("capped flag on a transaction that does not end the run");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_EMIT) |-> remain_reg != '0)
        else $error("emitting with no outputs left in the run");
`endif

endmodule

`default_nettype wire

@@ src/fractional_rate_converter.sv @@
// fractional_rate_converter: linear interpolation rate converter top level;
// uses frc_pkg, frc_front, frc_queue and frc_back
// steps: front phase loop for an input with N outputs, then queue, multiply,
// bit-serial divide of SAMPLE_BITS quotient bits and output register to the first output
// throughput: one output per cycle in a run while out_ready is high; front takes an input only
// when idle, queue lets it run ahead of the back; reset: async active low, steps 1, samples 128, phase 1
`default_nettype none

module fractional_rate_converter (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [frc_pkg::SAMPLE_BITS-1:0] in_sample,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [frc_pkg::SAMPLE_BITS-1:0] out_sample,
    output logic                            run_last,
    output logic                            run_capped,
    input  logic                            cfg_wr_en,
    input  logic [frc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [frc_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import frc_pkg::*;

    job_t push_job;
    job_t pop_job;
    logic job_push;
    logic job_pop;
    logic job_full;
    logic job_empty;

    frc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_sample (in_sample),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .job       (push_job),
        .job_push  (job_push),
        .job_full  (job_full)
    );

    frc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_push),
        .push_data (push_job),
        .full      (job_full),
        .pop       (job_pop),
        .pop_data  (pop_job),
        .empty     (job_empty)
    );

    frc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .job        (pop_job),
        .job_empty  (job_empty),
        .job_pop    (job_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_sample (out_sample),
        .run_last   (run_last),
        .run_capped (run_capped)
    );

endmodule

`default_nettype wire
